@@ hw/rtl/xmodem_crc_block_receiver_macros.svh @@
// Assertion macros shared by the receiver's RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef XMODEM_CRC_BLOCK_RECEIVER_MACROS_SVH
`define XMODEM_CRC_BLOCK_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define XCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define XCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/xcr_pkg.sv @@
// Shared types, codes and the CRC-16/XMODEM byte update for the receiver.
// No dependencies.
package xcr_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_WR   = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_FAIL = 2'd3;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_RETRY   = 2'd1;
	localparam logic [1:0] CFG_BASE    = 2'd2;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  tx_byte;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic        last;
	} rsp_t;

	// One queued job: a single result, or the ACK, 'C', done sequence.
	typedef struct packed {
		logic        triple;
		logic [1:0]  kind;
		logic [7:0]  tx;
		logic [15:0] addr;
		logic [7:0]  data;
	} job_t;

	typedef struct packed {
		logic [7:0]  timeout_ticks;
		logic [7:0]  retry_limit;
		logic [15:0] dest_base;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/xcr_front.sv @@
// Front end: accepts input words, runs the protocol state and CRC check,
// and pushes result jobs into the queue. Depends on xcr_pkg.
module xcr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  xcr_pkg::cfg_t cfg,
	input  logic          req_fire,
	input  xcr_pkg::req_t req,
	output logic          push,
	output xcr_pkg::job_t push_job
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_WAIT, PH_SEQ, PH_DATA, PH_CRCH, PH_CRCL, PH_DONE, PH_FAIL
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  pos_q, pos_d;
	logic        hdr_q, hdr_d;
	logic [1:0]  eot_q, eot_d;
	logic [7:0]  restart_q, restart_d;
	logic [7:0]  idle_q, idle_d;
	logic [15:0] blk_q, blk_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crch_q, crch_d;

	logic          active;
	logic [7:0]    pos_inc;
	logic [7:0]    idle_inc;
	logic [7:0]    rc_inc;
	logic          job_v;
	xcr_pkg::job_t job;

	assign active   = (phase_q != PH_IDLE) && (phase_q != PH_DONE) && (phase_q != PH_FAIL);
	assign pos_inc  = pos_q + 8'd1;
	assign idle_inc = (idle_q != 8'hFF) ? idle_q + 8'd1 : idle_q;
	assign rc_inc   = (restart_q != 8'hFF) ? restart_q + 8'd1 : restart_q;

	always_comb begin
		logic do_nak;
		do_nak    = 1'b0;
		phase_d   = phase_q;
		pos_d     = pos_q;
		hdr_d     = hdr_q;
		eot_d     = eot_q;
		restart_d = restart_q;
		idle_d    = idle_q;
		blk_d     = blk_q;
		crc_d     = crc_q;
		crch_d    = crch_q;
		job_v     = 1'b0;
		job       = '0;
		if (req.opcode == xcr_pkg::OP_START) begin
			phase_d   = PH_WAIT;
			pos_d     = '0;
			hdr_d     = 1'b0;
			eot_d     = '0;
			restart_d = '0;
			idle_d    = '0;
			blk_d     = cfg.dest_base;
			crc_d     = '0;
			crch_d    = '0;
			job_v     = 1'b1;
			job.kind  = xcr_pkg::KIND_TX;
			job.tx    = xcr_pkg::CH_C;
		end else if (req.opcode == xcr_pkg::OP_TICK && active) begin
			idle_d = idle_inc;
			if (idle_inc > cfg.timeout_ticks) begin
				do_nak = 1'b1;
			end
		end else if (req.opcode == xcr_pkg::OP_BYTE && active) begin
			idle_d = '0;
			case (phase_q)
				PH_WAIT: begin
					if (req.rx_byte == xcr_pkg::CH_SOH) begin
						phase_d = PH_SEQ;
						pos_d   = '0;
						crc_d   = '0;
					end else if (req.rx_byte == xcr_pkg::CH_EOT) begin
						job_v    = 1'b1;
						job.kind = xcr_pkg::KIND_TX;
						if (eot_q == 2'd0) begin
							eot_d  = 2'd1;
							job.tx = xcr_pkg::CH_NAK;
						end else begin
							eot_d      = 2'd2;
							phase_d    = PH_DONE;
							job.triple = 1'b1;
						end
					end else begin
						do_nak = 1'b1;
					end
				end
				PH_SEQ: begin
					pos_d = pos_inc;
					if (pos_inc >= 8'd2) begin
						pos_d   = '0;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					crc_d = xcr_pkg::crc_byte(crc_q, req.rx_byte);
					if (hdr_q) begin
						job_v    = 1'b1;
						job.kind = xcr_pkg::KIND_WR;
						job.addr = blk_q + {8'd0, pos_q};
						job.data = req.rx_byte;
					end
					pos_d = pos_inc;
					if (pos_inc >= 8'(xcr_pkg::BLOCK_BYTES)) begin
						pos_d   = '0;
						phase_d = PH_CRCH;
					end
				end
				PH_CRCH: begin
					crch_d  = req.rx_byte;
					phase_d = PH_CRCL;
				end
				default: begin
					if ({crch_q, req.rx_byte} == crc_q) begin
						if (hdr_q) begin
							blk_d = blk_q + 16'(xcr_pkg::BLOCK_BYTES);
						end
						hdr_d    = 1'b1;
						pos_d    = '0;
						crc_d    = '0;
						phase_d  = PH_WAIT;
						job_v    = 1'b1;
						job.kind = xcr_pkg::KIND_TX;
						job.tx   = xcr_pkg::CH_ACK;
					end else begin
						do_nak = 1'b1;
					end
				end
			endcase
		end
		if (do_nak) begin
			idle_d   = '0;
			pos_d    = '0;
			crc_d    = '0;
			job_v    = 1'b1;
			job      = '0;
			phase_d  = PH_WAIT;
			if (!hdr_q) begin
				restart_d = rc_inc;
				if (rc_inc >= cfg.retry_limit) begin
					phase_d  = PH_FAIL;
					job.kind = xcr_pkg::KIND_FAIL;
				end else begin
					eot_d    = '0;
					job.kind = xcr_pkg::KIND_TX;
					job.tx   = xcr_pkg::CH_C;
				end
			end else begin
				job.kind = xcr_pkg::KIND_TX;
				job.tx   = xcr_pkg::CH_NAK;
			end
		end
	end

	assign push     = req_fire && job_v;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			hdr_q     <= 1'b0;
			eot_q     <= '0;
			restart_q <= '0;
			idle_q    <= '0;
			blk_q     <= '0;
			crc_q     <= '0;
			crch_q    <= '0;
		end else if (req_fire) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			hdr_q     <= hdr_d;
			eot_q     <= eot_d;
			restart_q <= restart_d;
			idle_q    <= idle_d;
			blk_q     <= blk_d;
			crc_q     <= crc_d;
			crch_q    <= crch_d;
		end
	end

endmodule

@@ hw/rtl/xcr_fifo.sv @@
// Short job queue between front and back ends.
// Depends on xcr_pkg and the assertion macro header.
`include "xmodem_crc_block_receiver_macros.svh"

module xcr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xcr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output xcr_pkg::job_t head
);

	xcr_pkg::job_t               mem_q [xcr_pkg::QDEPTH];
	logic [xcr_pkg::QAW-1:0]     wr_q, rd_q;
	logic [xcr_pkg::QAW:0]       cnt_q;

	assign full     = (cnt_q == (xcr_pkg::QAW+1)'(xcr_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (xcr_pkg::QAW+1)'(push) - (xcr_pkg::QAW+1)'(pop);
		end
	end

	`XCR_ASSERT_IMP(a_no_overflow, push, !full || pop, "push into full queue")
	`XCR_ASSERT_IMP(a_no_underflow, pop, nonempty, "pop from empty queue")
	`XCR_ASSERT_NXT(a_count_tracks, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

@@ hw/rtl/xcr_back.sv @@
// Back end: expands queued jobs into result words held in an output register.
// Depends on xcr_pkg and the assertion macro header.
`include "xmodem_crc_block_receiver_macros.svh"

module xcr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  xcr_pkg::job_t job,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output xcr_pkg::rsp_t rsp
);

	logic          rsp_valid_q;
	xcr_pkg::rsp_t rsp_q;
	logic [1:0]    step_q;
	logic          load;
	logic          emit;
	logic          job_end;
	xcr_pkg::rsp_t nxt;

	assign load    = !rsp_valid_q || rsp_ready;
	assign emit    = load && job_valid;
	assign job_end = !job.triple || (step_q == 2'd2);
	assign pop     = emit && job_end;

	always_comb begin
		nxt             = '0;
		nxt.last        = job_end;
		if (job.triple) begin
			case (step_q)
				2'd0: begin
					nxt.result_kind = xcr_pkg::KIND_TX;
					nxt.tx_byte     = xcr_pkg::CH_ACK;
				end
				2'd1: begin
					nxt.result_kind = xcr_pkg::KIND_TX;
					nxt.tx_byte     = xcr_pkg::CH_C;
				end
				default: begin
					nxt.result_kind = xcr_pkg::KIND_DONE;
				end
			endcase
		end else begin
			nxt.result_kind = job.kind;
			nxt.tx_byte     = job.tx;
			nxt.write_addr  = job.addr;
			nxt.write_data  = job.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			rsp_valid_q <= job_valid;
			if (emit) begin
				step_q <= job_end ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`XCR_ASSERT_IMP(a_step_in_triple, step_q != 2'd0, job_valid && job.triple, "step without sequence job")
	`XCR_ASSERT_IMP(a_step_range, 1'b1, step_q != 2'd3, "sequence step out of range")
	`XCR_ASSERT_NXT(a_pop_last, pop, rsp_valid && rsp.last, "job retired without last word")

endmodule

@@ hw/rtl/xmodem_crc_block_receiver.sv @@
// XMODEM-CRC block receiver with a header first block: an input word is a start
// command, a received byte or a slow tick, and each one yields zero to three result
// words (transmit byte, memory write, done or failed). One input word is taken every
// cycle while the four-entry job queue between the protocol front end and the result
// back end has room; each result word is its own output word, so the end-of-transfer
// sequence yields three result words. Configuration writes take effect at once
// and belong in idle periods; dest_base is latched by each start command.
// Depends on xcr_pkg, xcr_front, xcr_fifo and xcr_back.
module xmodem_crc_block_receiver (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  xcr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output xcr_pkg::rsp_t rsp
);

	xcr_pkg::cfg_t cfg_q;
	logic          req_fire;
	logic          push, full, pop, nonempty;
	xcr_pkg::job_t push_job, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 8'd4;
			cfg_q.retry_limit   <= 8'd20;
			cfg_q.dest_base     <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				xcr_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata[7:0];
				xcr_pkg::CFG_RETRY:   cfg_q.retry_limit   <= cfg_wdata[7:0];
				xcr_pkg::CFG_BASE:    cfg_q.dest_base     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign req_ready = !full;
	assign req_fire  = req_valid && req_ready;

	xcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_fire (req_fire),
		.req      (req),
		.push     (push),
		.push_job (push_job)
	);

	xcr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	xcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (nonempty),
		.job       (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
